@@ design/cvr_pkg.sv @@
// shared types and constants for the planar vector rotator
`default_nettype none
package cvr_pkg;

  localparam int COORD_W   = 32;
  localparam int ANGLE_W   = 20;
  localparam int XW        = 48;
  localparam int ZW        = 33;
  localparam int WZW       = 35;
  localparam int PROD_W    = 64;
  localparam int TABLE_LEN = 32;
  localparam int STAGES_DEF = 16;

  localparam logic signed [WZW-1:0] ANG_PI      = 35'sd3373259426;
  localparam logic signed [WZW-1:0] ANG_TWO_PI  = 35'sd6746518852;
  localparam logic signed [ZW-1:0]  ANG_HALF_PI = 33'sd1686629713;
  localparam logic signed [COORD_W-1:0] GAIN_K  = 32'sd652032874;

  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
    32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cvr_vec_t;

endpackage
`default_nettype wire

@@ design/cvr_if.sv @@
// transaction channels for points in and rotated points out
`default_nettype none
interface cvr_in_if
  import cvr_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [ANGLE_W-1:0] turn_angle;

  modport source(output valid, action, point_x, point_y, turn_angle, input ready);
  modport sink(input valid, action, point_x, point_y, turn_angle, output ready);
endinterface

interface cvr_out_if
  import cvr_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] rotated_x;
  logic signed [COORD_W-1:0] rotated_y;

  modport source(output valid, rotated_x, rotated_y, input ready);
  modport sink(input valid, rotated_x, rotated_y, output ready);
endinterface
`default_nettype wire

@@ design/cvr_prep.sv @@
// angle reduction, gain multiply and quarter turn, two register stages
`default_nettype none
module cvr_prep
  import cvr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      up_valid,
  output logic                           up_ready,
  input  wire logic                      action,
  input  wire logic signed [COORD_W-1:0] point_x,
  input  wire logic signed [COORD_W-1:0] point_y,
  input  wire logic signed [ANGLE_W-1:0] turn_angle,
  output logic                           dn_valid,
  input  wire logic                      dn_ready,
  output cvr_vec_t                       dn_data
);

  // stage a: products and reduced angle
  logic                     a_valid;
  logic                     a_ready;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [ZW-1:0]     a_z;

  logic signed [PROD_W-1:0] prod_x_next;
  logic signed [PROD_W-1:0] prod_y_next;
  logic signed [WZW-1:0]    wz;
  logic signed [WZW-1:0]    wz_neg;
  logic signed [WZW-1:0]    wz_red;

  always_comb begin
    wz = WZW'(turn_angle) <<< 14;
    wz_neg = action ? -wz : wz;
    if (wz_neg > ANG_PI) begin
      wz_red = wz_neg - ANG_TWO_PI;
    end else if (wz_neg < -ANG_PI) begin
      wz_red = wz_neg + ANG_TWO_PI;
    end else begin
      wz_red = wz_neg;
    end
    prod_x_next = PROD_W'(point_x) * PROD_W'(GAIN_K);
    prod_y_next = PROD_W'(point_y) * PROD_W'(GAIN_K);
  end

  assign up_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (up_ready) begin
      a_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      prod_x <= prod_x_next;
      prod_y <= prod_y_next;
      a_z    <= wz_red[ZW-1:0];
    end
  end

  // stage b: scale down and quarter turn
  logic signed [XW-1:0] sx;
  logic signed [XW-1:0] sy;
  cvr_vec_t             b_next;

  always_comb begin
    sx = XW'(prod_x >>> 16);
    sy = XW'(prod_y >>> 16);
    if (a_z > ANG_HALF_PI) begin
      b_next.x = -sy;
      b_next.y = sx;
      b_next.z = a_z - ANG_HALF_PI;
    end else if (a_z < -ANG_HALF_PI) begin
      b_next.x = sy;
      b_next.y = -sx;
      b_next.z = a_z + ANG_HALF_PI;
    end else begin
      b_next.x = sx;
      b_next.y = sy;
      b_next.z = a_z;
    end
  end

  assign a_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (a_ready) begin
      dn_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && a_ready) begin
      dn_data <= b_next;
    end
  end

endmodule
`default_nettype wire

@@ design/cvr_stage.sv @@
// one registered cordic micro-rotation
`default_nettype none
module cvr_stage
  import cvr_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     up_valid,
  output logic          up_ready,
  input  wire cvr_vec_t up_data,
  output logic          dn_valid,
  input  wire logic     dn_ready,
  output cvr_vec_t      dn_data
);

  localparam logic signed [ZW-1:0] ATAN_I = ZW'(ATAN_TAB[IDX]);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  cvr_vec_t             data_next;

  always_comb begin
    dx = up_data.x >>> IDX;
    dy = up_data.y >>> IDX;
    if (!up_data.z[ZW-1]) begin
      data_next.x = up_data.x - dy;
      data_next.y = up_data.y + dx;
      data_next.z = up_data.z - ATAN_I;
    end else begin
      data_next.x = up_data.x + dy;
      data_next.y = up_data.y - dx;
      data_next.z = up_data.z + ATAN_I;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= data_next;
    end
  end

endmodule
`default_nettype wire

@@ design/cvr_round.sv @@
// rounding to q16.16 with saturation, output register
`default_nettype none
module cvr_round
  import cvr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     up_valid,
  output logic          up_ready,
  input  wire cvr_vec_t up_data,
  cvr_out_if.source     result
);

  localparam int RW = XW + 1;
  localparam logic signed [RW-1:0] HALF_LSB = RW'(8192);
  localparam logic signed [RW-1:0] SAT_MAX  = RW'(2147483647);
  localparam logic signed [RW-1:0] SAT_MIN  = -(RW'(2147483647)) - RW'(1);

  function automatic logic signed [COORD_W-1:0] finish(input logic signed [XW-1:0] v);
    logic signed [RW-1:0] r;
    r = (RW'(v) + HALF_LSB) >>> 14;
    if (r > SAT_MAX) begin
      return SAT_MAX[COORD_W-1:0];
    end else if (r < SAT_MIN) begin
      return SAT_MIN[COORD_W-1:0];
    end
    return r[COORD_W-1:0];
  endfunction

  assign up_ready = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (up_ready) begin
      result.valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      result.rotated_x <= finish(up_data.x);
      result.rotated_y <= finish(up_data.y);
    end
  end

endmodule
`default_nettype wire

@@ design/planar_vector_rotator.sv @@
// an accepted transaction passes two prep stages, a register for each
// cordic micro-rotation and one output stage on its way to the result
// throughput: one point per cycle when not stalled, every stage has its
// own valid bit; a stalled output holds only the full stages behind it
// reset: synchronous, clears the valid bits only
`default_nettype none
module planar_vector_rotator
  import cvr_pkg::*;
#(
  parameter int STAGES = STAGES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  cvr_in_if.sink    operand,
  cvr_out_if.source result
);

  logic     valid [STAGES+1];
  logic     ready [STAGES+1];
  cvr_vec_t data  [STAGES+1];

  cvr_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (operand.valid),
    .up_ready   (operand.ready),
    .action     (operand.action),
    .point_x    (operand.point_x),
    .point_y    (operand.point_y),
    .turn_angle (operand.turn_angle),
    .dn_valid   (valid[0]),
    .dn_ready   (ready[0]),
    .dn_data    (data[0])
  );

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    cvr_stage #(
      .IDX (g)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (valid[g]),
      .up_ready (ready[g]),
      .up_data  (data[g]),
      .dn_valid (valid[g+1]),
      .dn_ready (ready[g+1]),
      .dn_data  (data[g+1])
    );
  end

  cvr_round u_round (
    .clk      (clk),
    .rst      (rst),
    .up_valid (valid[STAGES]),
    .up_ready (ready[STAGES]),
    .up_data  (data[STAGES]),
    .result   (result)
  );

endmodule
`default_nettype wire

@@ tb/rotation_checker.sv @@
// checker: predicts each rotated point and compares it with the rotator output
module rotation_checker
  import cvr_pkg::*;
#(
  parameter int STAGES = STAGES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  cvr_in_if         operand,
  cvr_out_if        result,
  output int        failures,
  output int        pending
);

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -64'sd2147483648;
  localparam int     ARCTAN_LEN  = 32;

  // atan(2^-i) in Q2.30
  localparam longint ARCTAN_Q30 [ARCTAN_LEN] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6,
    'h03FEAB76, 'h01FFD55B, 'h00FFFAAA, 'h007FFF55,
    'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF,
    'h00003FFF, 'h00001FFF, 'h00000FFF, 'h000007FF,
    'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008,
    'h00000004, 'h00000002, 'h00000001, 'h00000000
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } rot_point_t;

  rot_point_t rotated_q [$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  task automatic report_error(input string msg);
    $display("%0t rotation mismatch: %s", $time, msg);
    failures++;
  endtask

  // q16.30 to q16.16, round half up, saturate
  function automatic logic signed [COORD_W-1:0] round_sat(input longint v);
    longint r;
    r = (v + 64'sd8192) >>> 14;
    if (r > Q_MAX) r = Q_MAX;
    else if (r < Q_MIN) r = Q_MIN;
    return r[COORD_W-1:0];
  endfunction

  function automatic rot_point_t predict_rotation(
    input logic                      negate,
    input logic signed [COORD_W-1:0] px,
    input logic signed [COORD_W-1:0] py,
    input logic signed [ANGLE_W-1:0] ang
  );
    longint x, y, z, t, dx, dy;
    rot_point_t r;
    z = longint'(ang) * 64'sd16384;
    if (negate) z = -z;
    if (z > PI_Q30) z -= TWO_PI_Q30;
    else if (z < -PI_Q30) z += TWO_PI_Q30;
    x = (longint'(px) * GAIN_Q30) >>> 16;
    y = (longint'(py) * GAIN_Q30) >>> 16;
    // exact quarter turn brings the residual into [-pi/2, pi/2]
    if (z > HALF_PI_Q30) begin
      t = x;
      x = -y;
      y = t;
      z -= HALF_PI_Q30;
    end else if (z < -HALF_PI_Q30) begin
      t = x;
      x = y;
      y = -t;
      z += HALF_PI_Q30;
    end
    for (int i = 0; i < STAGES && i < ARCTAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ARCTAN_Q30[i];
      end else begin
        x += dx;
        y -= dy;
        z += ARCTAN_Q30[i];
      end
    end
    r.x = round_sat(x);
    r.y = round_sat(y);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rot_point_t want;
    if (rst) begin
      rotated_q.delete();
    end else begin
      if (operand.valid && operand.ready) begin
        rotated_q.push_back(predict_rotation(operand.action, operand.point_x,
                                             operand.point_y, operand.turn_angle));
      end
      if (result.valid && result.ready) begin
        if (rotated_q.size() == 0) begin
          report_error($sformatf("unexpected transaction x=%0d y=%0d",
                                 result.rotated_x, result.rotated_y));
        end else begin
          want = rotated_q.pop_front();
          if (result.rotated_x !== want.x)
            report_error($sformatf("rotated_x got %0d want %0d", result.rotated_x, want.x));
          if (result.rotated_y !== want.y)
            report_error($sformatf("rotated_y got %0d want %0d", result.rotated_y, want.y));
        end
      end
    end
    pending = rotated_q.size();
  end

endmodule

@@ tb/testbench.sv @@
// top level: drives points into the rotator, stalls its output and gives the verdict
module testbench;
  import cvr_pkg::*;

  localparam int ROT_STAGES   = STAGES_DEF;
  localparam int RANDOM_ITEMS = 950;
  localparam int EDGE_ITEMS   = 22;
  localparam int CALM_TAIL    = 120;
  localparam int SQUEEZE_AT   = 200;
  localparam int SQUEEZE_LEN  = 80;

  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fffffff;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh80000000;
  localparam logic signed [COORD_W-1:0] C_ONE = 32'sd65536;

  typedef enum logic {
    ROTATE_POS = 1'b0,
    ROTATE_NEG = 1'b1
  } turn_dir_t;

  typedef struct packed {
    turn_dir_t                 dir;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [ANGLE_W-1:0] ang;
  } point_txn_t;

  // angles next to pi, pi/2 and the ends of the field
  localparam logic signed [ANGLE_W-1:0] BOUNDARY_ANG [10] = '{
    20'sd205887, 20'sd205888, -20'sd205887, -20'sd205888,
    20'sd102943, 20'sd102944, -20'sd102943, -20'sd102944,
    20'sd524287, -20'sd524288
  };

  localparam logic signed [COORD_W-1:0] EXTREME_COORD [4] = '{
    32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1
  };

  localparam point_txn_t EDGE_POINTS [EDGE_ITEMS] = '{
    '{ROTATE_POS, C_ONE, 32'sd0, 20'sd0},
    '{ROTATE_POS, C_MAX, C_MAX, 20'sd0},
    '{ROTATE_POS, C_MIN, C_MIN, 20'sd0},
    '{ROTATE_POS, C_MAX, C_MIN, 20'sd51472},
    '{ROTATE_NEG, C_MIN, C_MAX, 20'sd51472},
    '{ROTATE_NEG, C_ONE, 32'sd0, -20'sd524288},
    '{ROTATE_POS, C_ONE, 32'sd0, -20'sd524288},
    '{ROTATE_POS, C_ONE, C_ONE, 20'sd524287},
    '{ROTATE_NEG, C_ONE, C_ONE, 20'sd524287},
    '{ROTATE_POS, 32'sd100000, -32'sd50000, 20'sd205887},
    '{ROTATE_POS, 32'sd100000, -32'sd50000, 20'sd205888},
    '{ROTATE_POS, 32'sd100000, -32'sd50000, -20'sd205887},
    '{ROTATE_POS, 32'sd100000, -32'sd50000, -20'sd205888},
    '{ROTATE_POS, 32'sd100000, -32'sd50000, 20'sd102943},
    '{ROTATE_POS, 32'sd100000, -32'sd50000, 20'sd102944},
    '{ROTATE_POS, 32'sd100000, -32'sd50000, -20'sd102943},
    '{ROTATE_POS, 32'sd100000, -32'sd50000, -20'sd102944},
    '{ROTATE_NEG, 32'sd100000, -32'sd50000, 20'sd102944},
    '{ROTATE_POS, 32'sd0, 32'sd0, 20'sd12345},
    '{ROTATE_POS, C_MAX, 32'sd0, 20'sd102944},
    '{ROTATE_POS, C_MIN, 32'sd0, -20'sd102944},
    '{ROTATE_NEG, -32'sd1, 32'sd1, 20'sd1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   failures;
  int   pending;
  int   accepted_cnt = 0;
  bit   quiet = 1'b0;
  bit   squeeze_on = 1'b0;
  bit   squeeze_done = 1'b0;
  bit   tx_gappy = 1'b1;

  cvr_in_if  operand ();
  cvr_out_if result ();

  planar_vector_rotator #(
    .STAGES(ROT_STAGES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .operand(operand),
    .result (result)
  );

  rotation_checker #(
    .STAGES(ROT_STAGES)
  ) checker_i (
    .clk     (clk),
    .rst     (rst),
    .operand (operand),
    .result  (result),
    .failures(failures),
    .pending (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("[planar_vector_rotator] ERROR");
    $finish;
  end

  task automatic send_point(input point_txn_t p);
    operand.valid      <= 1'b1;
    operand.action     <= p.dir;
    operand.point_x    <= p.x;
    operand.point_y    <= p.y;
    operand.turn_angle <= p.ang;
    @(posedge clk);
    while (!operand.ready) @(posedge clk);
    accepted_cnt++;
    quiet = accepted_cnt >= EDGE_ITEMS + RANDOM_ITEMS - CALM_TAIL;
    if (!quiet && !squeeze_on && tx_gappy && $urandom_range(0, 3) == 0) begin
      operand.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // receiver side, including one long hold-off that backs up the pipeline
  initial begin : sink_side
    int  rx_cycles;
    bit  rx_calm;
    rx_cycles = 0;
    rx_calm = 1'b0;
    result.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      rx_cycles++;
      if (rx_cycles % 128 == 0) rx_calm = $urandom_range(0, 2) == 0;
      if (!squeeze_done && accepted_cnt >= SQUEEZE_AT) begin
        squeeze_done = 1'b1;
        squeeze_on = 1'b1;
        result.ready <= 1'b0;
        repeat (SQUEEZE_LEN) @(posedge clk);
        squeeze_on = 1'b0;
      end else if (!quiet && !rx_calm && $urandom_range(0, 5) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        result.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : source_side
    point_txn_t p;
    int         kind;
    operand.valid      <= 1'b0;
    operand.action     <= ROTATE_POS;
    operand.point_x    <= '0;
    operand.point_y    <= '0;
    operand.turn_angle <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < EDGE_ITEMS; n++) send_point(EDGE_POINTS[n]);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) tx_gappy = $urandom_range(0, 2) != 0;
      kind  = $urandom_range(0, 9);
      p.dir = turn_dir_t'($urandom_range(0, 1));
      p.ang = ANGLE_W'($urandom);
      if (kind <= 5) begin
        p.x = COORD_W'($urandom);
        p.y = COORD_W'($urandom);
      end else if (kind <= 7) begin
        p.x = COORD_W'(int'($urandom_range(0, 2097152)) - 1048576);
        p.y = COORD_W'(int'($urandom_range(0, 2097152)) - 1048576);
      end else if (kind == 8) begin
        p.x = EXTREME_COORD[$urandom_range(0, 3)];
        p.y = EXTREME_COORD[$urandom_range(0, 3)];
      end else begin
        p.x = COORD_W'($urandom);
        p.y = COORD_W'($urandom);
        p.ang = BOUNDARY_ANG[$urandom_range(0, 9)]
              + ANGLE_W'(int'($urandom_range(0, 4)) - 2);
      end
      send_point(p);
    end
    operand.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (ROT_STAGES + 8) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("[planar_vector_rotator] OK");
    end else begin
      $display("[planar_vector_rotator] ERROR");
    end
    $finish;
  end

endmodule

@@ planar_vector_rotator.f @@
design/cvr_pkg.sv
design/cvr_if.sv
design/cvr_prep.sv
design/cvr_stage.sv
design/cvr_round.sv
design/planar_vector_rotator.sv
tb/rotation_checker.sv
tb/testbench.sv
